FILE: rtl/assert_macros.svh
// Assertion macros shared by the effective address unit RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CEAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CEAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/ceau_pkg.sv
// Types and constants for the effective address unit.
// Depends on nothing; used by ceau_resolve and cpu_effective_address_unit.
`default_nettype none

package ceau_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_READ_DATA = 1'b1;

    localparam logic [2:0] MODE_ZERO_PAGE = 3'd0;
    localparam logic [2:0] MODE_ABSOLUTE = 3'd1;
    localparam logic [2:0] MODE_INDIRECT = 3'd2;
    localparam logic [2:0] MODE_INDEXED_INDIRECT = 3'd3;
    localparam logic [2:0] MODE_INDIRECT_INDEXED = 3'd4;
    localparam logic [2:0] MODE_IMMEDIATE = 3'd5;
    localparam logic [2:0] MODE_RELATIVE = 3'd6;
    localparam logic [2:0] MODE_RESERVED = 3'd7;

    localparam logic KIND_FINAL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_FIRST = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    localparam logic [2:0] CYC_ZP_ABS = 3'd3;
    localparam logic [2:0] CYC_INDIRECT = 3'd5;
    localparam logic [2:0] CYC_IMM_REL = 3'd2;

    typedef struct packed {
        logic        operation;
        logic [2:0]  mode;
        logic [7:0]  operand_low;
        logic [7:0]  operand_high;
        logic [7:0]  index_value;
        logic        read_access;
        logic [15:0] pc;
        logic [7:0]  read_data;
    } t_in_req;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [2:0]  cycles;
    } t_out_req;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] pointer_page;
        logic [7:0] pointer_offset;
        logic [7:0] fetched_low;
        logic [7:0] saved_index;
        logic       saved_read_flag;
        logic       post_index_pending;
    } t_ctx;

    typedef struct packed {
        logic     emit;
        t_out_req rsp;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/cpu_effective_address_unit.sv
// Throughput: one request per cycle while o_in_stall is low; the resolution logic
// sits between the context register and a result register backed by a one-entry
// skid stage.
// Reset (synchronous, active low) empties both output stages and clears the context.
// Top level of the effective address unit; depends on ceau_pkg, ceau_resolve
// and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpu_effective_address_unit (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  ceau_pkg::t_in_req  i_in_req,
    input  wire                logic i_in_valid,
    output logic               o_in_stall,
    output ceau_pkg::t_out_req o_out_req,
    output logic               o_out_valid,
    input  wire                logic i_out_stall
);

    ceau_pkg::t_ctx     r_ctx;
    ceau_pkg::t_ctx     n_ctx;
    ceau_pkg::t_ctx     calc_ctx;
    ceau_pkg::t_result  calc_res;
    ceau_pkg::t_out_req r_out;
    ceau_pkg::t_out_req n_out;
    ceau_pkg::t_out_req r_skid;
    ceau_pkg::t_out_req n_skid;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_skid_valid;
    logic               n_skid_valid;
    logic               in_accept;
    logic               slot_free;

    ceau_resolve u_resolve (
        .i_req (i_in_req),
        .i_ctx (r_ctx),
        .o_ctx (calc_ctx),
        .o_res (calc_res)
    );

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign slot_free   = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_ctx = in_accept ? calc_ctx : r_ctx;
        n_out = r_out;
        n_out_valid = r_out_valid;
        n_skid = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (slot_free) begin
                n_out = r_skid;
                n_out_valid = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (in_accept && calc_res.emit) begin
            if (slot_free) begin
                n_out = calc_res.rsp;
                n_out_valid = 1'b1;
            end else begin
                n_skid = calc_res.rsp;
                n_skid_valid = 1'b1;
            end
        end else if (slot_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_ctx <= n_ctx;
            r_out_valid <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skid <= n_skid;
    end

    `CEAU_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CEAU_ASSERT_IMP(a_post_index_busy, i_clk, i_rst_n, r_ctx.post_index_pending,
                     r_ctx.phase != ceau_pkg::PHASE_IDLE)
    `CEAU_ASSERT_IMP(a_second_after_first, i_clk, i_rst_n,
                     r_ctx.phase == ceau_pkg::PHASE_SECOND,
                     $past(r_ctx.phase) == ceau_pkg::PHASE_FIRST
                     || $past(r_ctx.phase) == ceau_pkg::PHASE_SECOND)
    `CEAU_ASSERT_NXT(a_blocked_result_skids, i_clk, i_rst_n,
                     in_accept && calc_res.emit && r_out_valid && i_out_stall,
                     r_skid_valid)

endmodule

`default_nettype wire

FILE: rtl/ceau_resolve.sv
// Combinational address resolution: next context and optional result per request.
// Depends on ceau_pkg.
`default_nettype none

module ceau_resolve (
    input  ceau_pkg::t_in_req i_req,
    input  ceau_pkg::t_ctx    i_ctx,
    output ceau_pkg::t_ctx    o_ctx,
    output ceau_pkg::t_result o_res
);

    logic [8:0]  abs_low_sum;
    logic [15:0] rel_disp;
    logic [15:0] rel_addr;
    logic [15:0] ind_base;
    logic [15:0] ind_addr;
    logic [7:0]  ptr_page;
    logic [7:0]  ptr_offset;

    always_comb begin
        abs_low_sum = {1'b0, i_req.operand_low} + {1'b0, i_req.index_value};
        rel_disp = {{8{i_req.operand_low[7]}}, i_req.operand_low};
        rel_addr = i_req.pc + rel_disp;
        ind_base = {i_req.read_data, i_ctx.fetched_low};
        ind_addr = ind_base + {8'h00, i_ctx.saved_index};
        ptr_page = (i_req.mode == ceau_pkg::MODE_INDIRECT) ? i_req.operand_high : 8'h00;
        ptr_offset = (i_req.mode == ceau_pkg::MODE_INDEXED_INDIRECT)
                   ? 8'(i_req.operand_low + i_req.index_value) : i_req.operand_low;

        o_ctx = i_ctx;
        o_res = '0;

        if (i_req.operation == ceau_pkg::OP_START) begin
            o_ctx.phase = ceau_pkg::PHASE_IDLE;
            o_ctx.post_index_pending = 1'b0;
            case (i_req.mode)
                ceau_pkg::MODE_ZERO_PAGE: begin
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_FINAL;
                    o_res.rsp.address = {8'h00, 8'(i_req.operand_low + i_req.index_value)};
                    o_res.rsp.cycles = ceau_pkg::CYC_ZP_ABS;
                end
                ceau_pkg::MODE_ABSOLUTE: begin
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_FINAL;
                    o_res.rsp.address = {i_req.operand_high, i_req.operand_low}
                                      + {8'h00, i_req.index_value};
                    o_res.rsp.cycles = ceau_pkg::CYC_ZP_ABS
                                     + {2'b00, i_req.read_access & abs_low_sum[8]};
                end
                ceau_pkg::MODE_INDIRECT,
                ceau_pkg::MODE_INDEXED_INDIRECT,
                ceau_pkg::MODE_INDIRECT_INDEXED: begin
                    o_ctx.phase = ceau_pkg::PHASE_FIRST;
                    o_ctx.pointer_page = ptr_page;
                    o_ctx.pointer_offset = ptr_offset;
                    o_ctx.saved_index = i_req.index_value;
                    o_ctx.saved_read_flag = i_req.read_access;
                    o_ctx.post_index_pending =
                        (i_req.mode == ceau_pkg::MODE_INDIRECT_INDEXED);
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_READ;
                    o_res.rsp.address = {ptr_page, ptr_offset};
                    o_res.rsp.cycles = 3'd0;
                end
                ceau_pkg::MODE_IMMEDIATE: begin
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_FINAL;
                    o_res.rsp.address = {8'h00, i_req.operand_low};
                    o_res.rsp.cycles = ceau_pkg::CYC_IMM_REL;
                end
                ceau_pkg::MODE_RELATIVE: begin
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_FINAL;
                    o_res.rsp.address = rel_addr;
                    o_res.rsp.cycles = ceau_pkg::CYC_IMM_REL
                                     + {2'b00, rel_addr[15:8] != i_req.pc[15:8]};
                end
                default: begin
                    o_res.emit = 1'b0;
                end
            endcase
        end else begin
            case (i_ctx.phase)
                ceau_pkg::PHASE_FIRST: begin
                    o_ctx.fetched_low = i_req.read_data;
                    o_ctx.phase = ceau_pkg::PHASE_SECOND;
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_READ;
                    o_res.rsp.address = {i_ctx.pointer_page,
                                         8'(i_ctx.pointer_offset + 8'd1)};
                    o_res.rsp.cycles = 3'd0;
                end
                ceau_pkg::PHASE_SECOND: begin
                    o_ctx.phase = ceau_pkg::PHASE_IDLE;
                    o_ctx.post_index_pending = 1'b0;
                    o_res.emit = 1'b1;
                    o_res.rsp.kind = ceau_pkg::KIND_FINAL;
                    if (i_ctx.post_index_pending) begin
                        o_res.rsp.address = ind_addr;
                        o_res.rsp.cycles = ceau_pkg::CYC_INDIRECT
                            + {2'b00, i_ctx.saved_read_flag
                                      & (ind_addr[15:8] != ind_base[15:8])};
                    end else begin
                        o_res.rsp.address = ind_base;
                        o_res.rsp.cycles = ceau_pkg::CYC_INDIRECT;
                    end
                end
                default: begin
                    o_ctx.phase = ceau_pkg::PHASE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
